// ===== rtl/sbbpc_pkg.sv =====
// shared types and constants of the swept box brush plane clip block
`default_nettype none
package sbbpc_pkg;

  localparam int VW = 32;  // q16.16 vector component
  localparam int DW = 56;  // endpoint distance and divider operands
  localparam int RW = DW + 1;
  localparam int PW = 49;  // floored q16.16 product
  localparam int FW = 17;  // hit fraction
  localparam int EW = 16;  // distance epsilon
  localparam int QW = 32;  // divider quotient

  localparam logic [FW-1:0] FRAC_ONE  = 17'h10000;
  localparam logic [EW-1:0] EPS_RESET = 16'd2048;
  localparam logic [3:0]    MUL_LAST  = 4'd8;
  localparam logic [4:0]    DIV_LAST  = 5'd31;

  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_DELTA   = 2'd1,
    CMD_EXTENTS = 2'd2,
    CMD_PLANE   = 2'd3
  } cmd_code_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_ACC,
    ST_EVAL,
    ST_DSETUP,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [3:0] mul_idx;
    logic       eval_en;
    logic       div_init;
    logic       div_step;
    logic       update_en;
    logic       finish_en;
  } dp_cmd_t;

  typedef struct packed {
    logic in_plane;
    logic skip_test;
    logic last;
    logic need_div;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/sbbpc_if.sv =====
// channel interfaces of the swept box brush plane clip block
`default_nettype none
interface sbbpc_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic signed [31:0] plane_dist;
  logic               is_ray;
  logic               bevel;
  logic               last_plane;

  modport source (output valid, command, vec_x, vec_y, vec_z, plane_dist, is_ray, bevel,
                  last_plane, input ready);
  modport sink (input valid, command, vec_x, vec_y, vec_z, plane_dist, is_ray, bevel,
                last_plane, output ready);
endinterface

interface sbbpc_result_if;
  logic               valid;
  logic               ready;
  logic [16:0]        fraction;
  logic signed [31:0] hit_normal_x;
  logic signed [31:0] hit_normal_y;
  logic signed [31:0] hit_normal_z;
  logic               start_solid;
  logic               all_solid;
  logic               brush_hit;

  modport source (output valid, fraction, hit_normal_x, hit_normal_y, hit_normal_z,
                  start_solid, all_solid, brush_hit, input ready);
  modport sink (input valid, fraction, hit_normal_x, hit_normal_y, hit_normal_z,
                start_solid, all_solid, brush_hit, output ready);
endinterface

interface sbbpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/sbbpc_ctrl.sv =====
// sequencing state machine of the swept box brush plane clip block
`default_nettype none
module sbbpc_ctrl
  import sbbpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.in_plane) state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.skip_test) begin
          state_next = stat.last ? ST_FINISH : ST_IDLE;
        end else begin
          state_next = ST_MUL;
          cnt_next   = '0;
        end
      end
      ST_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_idx = cnt[3:0];
        if (cnt[3:0] == MUL_LAST) state_next = ST_ACC;
        else cnt_next = cnt + 5'd1;
      end
      ST_ACC: state_next = ST_EVAL;
      ST_EVAL: begin
        cmd.eval_en = 1'b1;
        if (stat.need_div) state_next = ST_DSETUP;
        else state_next = stat.last ? ST_FINISH : ST_IDLE;
      end
      ST_DSETUP: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_LAST) state_next = ST_UPDATE;
        else cnt_next = cnt + 5'd1;
      end
      ST_UPDATE: begin
        cmd.update_en = 1'b1;
        state_next    = stat.last ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish_en = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/sbbpc_dp.sv =====
// datapath of the swept box brush plane clip block: trace state, multiplier, divider
`default_nettype none
module sbbpc_dp
  import sbbpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic [1:0]           in_command,
  input  logic signed [VW-1:0] in_vec_x,
  input  logic signed [VW-1:0] in_vec_y,
  input  logic signed [VW-1:0] in_vec_z,
  input  logic signed [VW-1:0] in_plane_dist,
  input  logic                 in_is_ray,
  input  logic                 in_bevel,
  input  logic                 in_last_plane,
  input  logic                 cfg_we,
  input  logic [EW-1:0]        cfg_data,
  input  logic                 res_ready,
  output logic                 res_valid,
  output logic [FW-1:0]        res_fraction,
  output logic signed [VW-1:0] res_normal_x,
  output logic signed [VW-1:0] res_normal_y,
  output logic signed [VW-1:0] res_normal_z,
  output logic                 res_start_solid,
  output logic                 res_all_solid,
  output logic                 res_brush_hit
);

  logic [EW-1:0]        eps;
  logic signed [VW-1:0] start_pt [3];
  logic signed [VW-1:0] end_pt [3];
  logic signed [VW-1:0] ext [3];
  logic                 ray_mode;
  logic signed [VW-1:0] it_n [3];
  logic signed [VW-1:0] in_vec [3];
  logic                 it_bevel, it_last;

  logic signed [VW-1:0] enter_f, leave_f;
  logic                 enter_valid, getout, startout, skip;
  logic signed [VW-1:0] clip_n [3];
  logic [FW-1:0]        best_f;
  logic signed [VW-1:0] best_n [3];
  logic                 solid_start, solid_all;

  logic signed [DW-1:0] d1, d2;
  logic signed [PW-1:0] prod;
  logic [1:0]           prod_grp;
  logic                 prod_valid;

  logic signed [DW-1:0] num;
  logic [DW-1:0]        den;
  logic                 enter_dir, neg, ovf;
  logic [RW-1:0]        rem;
  logic [QW-1:0]        shreg, quo;

  // multiplier operand selection
  logic [1:0]           lane;
  logic signed [VW:0]   mul_a;
  logic signed [VW-1:0] mul_b;
  logic signed [2*VW:0] prod_full;
  logic signed [DW-1:0] prod_ext;

  // classification and divider
  logic                 pos1, pos2;
  logic signed [DW-1:0] eps_ext;
  logic [DW-1:0]        mag;
  logic [RW-1:0]        r2;
  logic                 qbit;
  logic [QW:0]          q33;
  logic signed [VW-1:0] frac;

  // brush close
  logic                 hit;
  logic [FW-1:0]        best_f_next;
  logic                 solid_start_next, solid_all_next;

  assign in_vec[0] = in_vec_x;
  assign in_vec[1] = in_vec_y;
  assign in_vec[2] = in_vec_z;

  always_comb begin
    case (cmd.mul_idx)
      4'd0, 4'd3, 4'd6: lane = 2'd0;
      4'd1, 4'd4, 4'd7: lane = 2'd1;
      default:          lane = 2'd2;
    endcase
    mul_b = it_n[lane];
    if (cmd.mul_idx < 4'd3) mul_a = {start_pt[lane][VW-1], start_pt[lane]};
    else if (cmd.mul_idx < 4'd6) mul_a = {end_pt[lane][VW-1], end_pt[lane]};
    else if (ray_mode) mul_a = '0;
    else if (mul_b < 0) mul_a = {ext[lane][VW-1], ext[lane]};
    else mul_a = (VW+1)'(0) - {ext[lane][VW-1], ext[lane]};
  end

  assign prod_full = mul_a * mul_b;
  assign prod_ext  = {{(DW-PW){prod[PW-1]}}, prod};

  assign pos1    = !d1[DW-1] && (|d1);
  assign pos2    = !d2[DW-1] && (|d2);
  assign eps_ext = $signed({{(DW-EW){1'b0}}, eps});
  assign mag     = num[DW-1] ? DW'(-num) : DW'(num);
  assign r2      = {rem[RW-2:0], shreg[QW-1]};
  assign qbit    = r2 >= {1'b0, den};

  always_comb begin
    q33 = ovf ? {1'b1, {QW{1'b0}}} : {1'b0, quo};
    if (neg) frac = (q33 > 33'h0_8000_0000) ? 32'sh8000_0000 : -$signed(q33[QW-1:0]);
    else frac = (q33 > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q33[QW-1:0]);
  end

  always_comb begin
    solid_start_next = solid_start || (!skip && !startout);
    solid_all_next   = solid_all || (!skip && !startout && !getout);
    hit = !skip && startout && enter_valid && (enter_f < leave_f) &&
          ($signed({enter_f[VW-1], enter_f}) < $signed({{(VW+1-FW){1'b0}}, best_f}));
    if (!hit) best_f_next = best_f;
    else if (enter_f[VW-1]) best_f_next = '0;
    else best_f_next = enter_f[FW-1:0];
  end

  assign stat.in_plane  = cmd_code_t'(in_command) == CMD_PLANE;
  assign stat.skip_test = skip || (ray_mode && it_bevel);
  assign stat.last      = it_last;
  assign stat.need_div  = pos1 ^ pos2;
  assign stat.out_free  = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps         <= EPS_RESET;
      ray_mode    <= 1'b0;
      enter_f     <= '0;
      leave_f     <= $signed({{(VW-FW){1'b0}}, FRAC_ONE});
      enter_valid <= 1'b0;
      getout      <= 1'b0;
      startout    <= 1'b0;
      skip        <= 1'b0;
      best_f      <= FRAC_ONE;
      solid_start <= 1'b0;
      solid_all   <= 1'b0;
      prod_valid  <= 1'b0;
      res_valid   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        start_pt[i] <= '0;
        end_pt[i]   <= '0;
        ext[i]      <= '0;
        clip_n[i]   <= '0;
        best_n[i]   <= '0;
      end
    end else begin
      if (cfg_we) eps <= cfg_data;

      prod_valid <= cmd.mul_en;
      if (cmd.mul_en) begin
        prod <= prod_full[2*VW:16];
        if (cmd.mul_idx < 4'd3) prod_grp <= 2'd0;
        else if (cmd.mul_idx < 4'd6) prod_grp <= 2'd1;
        else prod_grp <= 2'd2;
      end
      if (prod_valid) begin
        if (prod_grp != 2'd1) d1 <= d1 + prod_ext;
        if (prod_grp != 2'd0) d2 <= d2 + prod_ext;
      end

      if (cmd.load) begin
        it_bevel <= in_bevel;
        it_last  <= in_last_plane;
        for (int i = 0; i < 3; i++) it_n[i] <= in_vec[i];
        case (cmd_code_t'(in_command))
          CMD_BEGIN: begin
            for (int i = 0; i < 3; i++) begin
              start_pt[i] <= in_vec[i];
              end_pt[i]   <= in_vec[i] + (end_pt[i] - start_pt[i]);
              clip_n[i]   <= '0;
              best_n[i]   <= '0;
            end
            ray_mode    <= in_is_ray;
            enter_f     <= '0;
            leave_f     <= $signed({{(VW-FW){1'b0}}, FRAC_ONE});
            enter_valid <= 1'b0;
            getout      <= 1'b0;
            startout    <= 1'b0;
            skip        <= 1'b0;
            best_f      <= FRAC_ONE;
            solid_start <= 1'b0;
            solid_all   <= 1'b0;
          end
          CMD_DELTA: begin
            for (int i = 0; i < 3; i++) end_pt[i] <= start_pt[i] + in_vec[i];
          end
          CMD_EXTENTS: begin
            for (int i = 0; i < 3; i++) ext[i] <= in_vec[i];
          end
          CMD_PLANE: begin
            d1 <= -{{(DW-VW){in_plane_dist[VW-1]}}, in_plane_dist};
            d2 <= -{{(DW-VW){in_plane_dist[VW-1]}}, in_plane_dist};
          end
          default: ;
        endcase
      end

      if (cmd.eval_en) begin
        if (pos1 && pos2) skip <= 1'b1;
        if (pos2) getout <= 1'b1;
        if (pos1) startout <= 1'b1;
        enter_dir <= pos1;
        num       <= pos1 ? d1 - eps_ext : -d1 - eps_ext;
        den       <= pos1 ? DW'(d1 - d2) : DW'(d2 - d1);
      end

      if (cmd.div_init) begin
        neg   <= num[DW-1];
        ovf   <= {16'b0, mag} >= {den, 16'b0};
        rem   <= RW'(mag >> 16);
        shreg <= {mag[15:0], 16'b0};
        quo   <= '0;
      end

      if (cmd.div_step) begin
        rem   <= qbit ? r2 - {1'b0, den} : r2;
        quo   <= {quo[QW-2:0], qbit};
        shreg <= {shreg[QW-2:0], 1'b0};
      end

      if (cmd.update_en) begin
        if (enter_dir) begin
          if (!enter_valid || frac > enter_f) begin
            enter_f     <= frac;
            enter_valid <= 1'b1;
            for (int i = 0; i < 3; i++) clip_n[i] <= it_n[i];
          end
        end else if (frac < leave_f) begin
          leave_f <= frac;
        end
      end

      if (cmd.finish_en) begin
        best_f      <= best_f_next;
        solid_start <= solid_start_next;
        solid_all   <= solid_all_next;
        if (hit) for (int i = 0; i < 3; i++) best_n[i] <= clip_n[i];
        enter_f     <= '0;
        leave_f     <= $signed({{(VW-FW){1'b0}}, FRAC_ONE});
        enter_valid <= 1'b0;
        getout      <= 1'b0;
        startout    <= 1'b0;
        skip        <= 1'b0;
        for (int i = 0; i < 3; i++) clip_n[i] <= '0;
        res_fraction    <= best_f_next;
        res_normal_x    <= hit ? clip_n[0] : best_n[0];
        res_normal_y    <= hit ? clip_n[1] : best_n[1];
        res_normal_z    <= hit ? clip_n[2] : best_n[2];
        res_start_solid <= solid_start_next;
        res_all_solid   <= solid_all_next;
        res_brush_hit   <= hit;
      end

      if (cmd.finish_en) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/swept_box_brush_plane_clip_core.sv =====
// top level of the swept box brush plane clip block
//
// Clips a swept point or axis-aligned box against convex brushes streamed in as
// planes; vectors and distances are Q16.16, the fraction 1.16. Begin, delta and
// extents transactions are taken in idle without leaving it, so they can arrive
// back to back. A plane transaction runs on a shared 33x32 multiplier (nine
// products, one per cycle) and, when the sweep crosses the plane, a radix-2
// restoring divider (32 quotient bits, one per cycle); a plane skipped inside a
// cut-off brush or a bevel in ray mode uses neither. The last plane of a brush
// posts the result, which waits in an output register while the next transaction
// is taken; a second result stalls until it drains.
// Write the epsilon register only while the block is idle.
`default_nettype none
module swept_box_brush_plane_clip_core
  import sbbpc_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  sbbpc_item_if.sink     item,
  sbbpc_result_if.source result,
  sbbpc_cfg_if.sink      cfg
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // epsilon register takes a write every cycle
  assign cfg.ready = 1'b1;

  // sequencer: accepts a transaction in idle and steps the datapath
  sbbpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // trace state, plane distance accumulation, fraction divider, output register
  sbbpc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_command      (item.command),
    .in_vec_x        (item.vec_x),
    .in_vec_y        (item.vec_y),
    .in_vec_z        (item.vec_z),
    .in_plane_dist   (item.plane_dist),
    .in_is_ray       (item.is_ray),
    .in_bevel        (item.bevel),
    .in_last_plane   (item.last_plane),
    .cfg_we          (cfg.valid),
    .cfg_data        (cfg.data),
    .res_ready       (result.ready),
    .res_valid       (result.valid),
    .res_fraction    (result.fraction),
    .res_normal_x    (result.hit_normal_x),
    .res_normal_y    (result.hit_normal_y),
    .res_normal_z    (result.hit_normal_z),
    .res_start_solid (result.start_solid),
    .res_all_solid   (result.all_solid),
    .res_brush_hit   (result.brush_hit)
  );

endmodule
`default_nettype wire

// ===== rtl/sbbpc_checker.sv =====
// port-level assertions of the swept box brush plane clip block
`default_nettype none
module sbbpc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [16:0] fraction,
  input wire logic        start_solid,
  input wire logic        all_solid,
  input wire logic        brush_hit
);

  // a stalled result stays posted
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a new hit is always closer than no hit
  a_hit_frac: assert property (@(posedge clk) disable iff (rst)
    out_valid && brush_hit |-> fraction < 17'h10000)
    else $error("hit with fraction of one");

  // all solid implies start solid
  a_solid: assert property (@(posedge clk) disable iff (rst)
    out_valid && all_solid |-> start_solid)
    else $error("all_solid without start_solid");

  // a result never posts right after a transaction is taken
  a_post_gap: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result posted too early");

endmodule

bind swept_box_brush_plane_clip_core sbbpc_checker u_sbbpc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (item.valid),
  .in_ready    (item.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .fraction    (result.fraction),
  .start_solid (result.start_solid),
  .all_solid   (result.all_solid),
  .brush_hit   (result.brush_hit)
);
`default_nettype wire
